// ===== hdl/sws_pkg.sv =====
// package for the stopwatch: mode codes, display constants and digit helpers
`timescale 1ns / 1ps

package sws_pkg;

   typedef logic [4:0][3:0] bcd_type;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_COUNT = 2'd1;
   localparam logic [1:0] MODE_SPLIT = 2'd2;

   localparam logic [5:0] LAST_TICK  = 6'd39;
   localparam logic [7:0] POINT_ONLY = 8'h7F;
   localparam logic [7:0] SEG_BLANK  = 8'hFF;

   localparam logic [2:0] CSR_MAX_SECONDS = 3'd0;

   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0: seg = 8'hC0;
         4'd1: seg = 8'hF9;
         4'd2: seg = 8'hA4;
         4'd3: seg = 8'hB0;
         4'd4: seg = 8'h99;
         4'd5: seg = 8'h92;
         4'd6: seg = 8'h82;
         4'd7: seg = 8'hF8;
         4'd8: seg = 8'h80;
         4'd9: seg = 8'h98;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   function automatic bcd_type bcd_inc(input bcd_type value);
      bcd_type result;
      logic    carry;
      result = value;
      carry  = 1'b1;
      for (int i = 0; i < 5; i++) begin
         if (carry) begin
            if (result[i] == 4'd9) begin
               result[i] = 4'd0;
            end else begin
               result[i] = result[i] + 4'd1;
               carry     = 1'b0;
            end
         end
      end
      return result;
   endfunction

   function automatic logic [2:0] digit_count(input bcd_type value);
      logic [2:0] count;
      priority if (value[4] != 4'd0) count = 3'd5;
      else if (value[3] != 4'd0) count = 3'd4;
      else if (value[2] != 4'd0) count = 3'd3;
      else if (value[1] != 4'd0) count = 3'd2;
      else count = 3'd1;
      return count;
   endfunction

   // slot of the 40-tick cycle, counted from the most significant digit
   function automatic logic [2:0] slot_of(input logic [2:0] count, input logic [5:0] t);
      logic [2:0] slot;
      unique case (count)
         3'd2: slot = (t <= 6'd20) ? 3'd0 : 3'd1;
         3'd3: begin
            priority if (t <= 6'd8) slot = 3'd0;
            else if (t <= 6'd24) slot = 3'd1;
            else slot = 3'd2;
         end
         3'd4: begin
            priority if (t <= 6'd10) slot = 3'd0;
            else if (t <= 6'd20) slot = 3'd1;
            else if (t <= 6'd30) slot = 3'd2;
            else slot = 3'd3;
         end
         3'd5: begin
            priority if (t <= 6'd8) slot = 3'd0;
            else if (t <= 6'd16) slot = 3'd1;
            else if (t <= 6'd24) slot = 3'd2;
            else if (t <= 6'd32) slot = 3'd3;
            else slot = 3'd4;
         end
         default: slot = 3'd0;
      endcase
      return slot;
   endfunction

   function automatic logic [7:0] display_of(input bcd_type value, input logic [5:0] t);
      logic [2:0] count;
      logic [2:0] index;
      count = digit_count(value);
      index = count - 3'd1 - slot_of(count, t);
      return seg_of(value[index]);
   endfunction

endpackage

// ===== hdl/stopwatch_split_seven_segment.sv =====
// top level of the stopwatch with split capture and multiplexed display
`timescale 1ns / 1ps

// Stopwatch with split capture. Each input transaction is one sample of the
// 40 Hz tick flag and the two button levels; each produces exactly one result
// transaction holding the state after that sample: the active-low segment
// pattern for the digit shown in the current tick slot (the point alone in
// split mode), the counted seconds, the last split and the mode. A sample is
// accepted in every cycle in which the previous result is taken or none is
// held, and its result appears in the output register in the next cycle;
// while a result is stalled the input is stalled too, so throughput is one
// transaction per cycle. The seconds are kept in binary and in a decimal
// shadow count, so the display needs no division.
// max_seconds lies at byte address 0 of the register port (reset 43200).
module stopwatch_split_seven_segment (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_tick,
   input  logic        req_button_a,
   input  logic        req_button_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_segments,
   output logic [15:0] rsp_seconds_now,
   output logic [15:0] rsp_split_seconds,
   output logic [1:0]  rsp_mode,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sws_pkg::*;

   logic [15:0]  max_seconds_ff;
   logic [1:0]   mode_ff, mode_in;
   logic [5:0]   ticks_ff, ticks_in;
   logic [15:0]  seconds_ff, seconds_in;
   sws_pkg::bcd_type bcd_ff, bcd_in;
   logic [15:0]  split_ff, split_in;
   logic         last_a_ff, last_b_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_segments_ff;
   logic [15:0]  rsp_seconds_ff;
   logic [15:0]  rsp_split_ff;
   logic [1:0]   rsp_mode_ff;

   logic         accept;
   logic         a_edge, b_edge;
   logic         wrap, advance;

   assign pready    = 1'b1;
   assign prdata    = (paddr == CSR_MAX_SECONDS) ? {16'd0, max_seconds_ff} : 32'd0;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign a_edge  = req_button_a && !last_a_ff;
   assign b_edge  = req_button_b && !last_b_ff;
   assign wrap    = ticks_ff >= LAST_TICK;
   assign advance = req_tick && (mode_ff == MODE_COUNT) && wrap
                    && (seconds_ff < max_seconds_ff);

   always_comb begin
      ticks_in   = ticks_ff;
      seconds_in = seconds_ff;
      bcd_in     = bcd_ff;
      split_in   = split_ff;
      mode_in    = mode_ff;
      if (req_tick && (mode_ff != MODE_SPLIT)) begin
         ticks_in = wrap ? 6'd0 : ticks_ff + 6'd1;
      end
      if (advance) begin
         seconds_in = seconds_ff + 16'd1;
         bcd_in     = bcd_inc(bcd_ff);
      end
      unique case (mode_ff)
         MODE_IDLE: begin
            if (a_edge) begin
               mode_in = MODE_COUNT;
            end else if (b_edge) begin
               seconds_in = 16'd0;
               bcd_in     = '0;
            end
         end
         MODE_COUNT: begin
            if (a_edge) begin
               mode_in = MODE_IDLE;
            end else if (b_edge) begin
               split_in = seconds_in;
               mode_in  = MODE_SPLIT;
            end
         end
         default: begin
            if (!req_button_b) mode_in = MODE_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_seconds_ff <= 16'd43200;
         mode_ff        <= MODE_IDLE;
         ticks_ff       <= 6'd0;
         seconds_ff     <= 16'd0;
         bcd_ff         <= '0;
         split_ff       <= 16'd0;
         last_a_ff      <= 1'b0;
         last_b_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && pready && (paddr == CSR_MAX_SECONDS)) begin
            max_seconds_ff <= pwdata[15:0];
         end
         if (accept) begin
            mode_ff    <= mode_in;
            ticks_ff   <= ticks_in;
            seconds_ff <= seconds_in;
            bcd_ff     <= bcd_in;
            split_ff   <= split_in;
            last_a_ff  <= req_button_a;
            last_b_ff  <= req_button_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_segments_ff <= (mode_in == MODE_SPLIT) ? POINT_ONLY
                                                    : display_of(bcd_in, ticks_in);
         rsp_seconds_ff  <= seconds_in;
         rsp_split_ff    <= split_in;
         rsp_mode_ff     <= mode_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segments      = rsp_segments_ff;
   assign rsp_seconds_now   = rsp_seconds_ff;
   assign rsp_split_seconds = rsp_split_ff;
   assign rsp_mode          = rsp_mode_ff;

   // decimal shadow count tracks the binary count
   assert property (@(posedge clock) disable iff (reset)
      {4'd0, seconds_ff} == 20'(bcd_ff[0]) + 20'(bcd_ff[1]) * 20'd10
         + 20'(bcd_ff[2]) * 20'd100 + 20'(bcd_ff[3]) * 20'd1000
         + 20'(bcd_ff[4]) * 20'd10000)
      else $error("decimal count out of step with seconds");

   assert property (@(posedge clock) disable iff (reset) ticks_ff <= LAST_TICK)
      else $error("subsecond ticks beyond last slot");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (rsp_seconds_ff == seconds_ff) && (rsp_mode_ff == mode_ff))
      else $error("result does not reflect updated state");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_mode_ff == MODE_SPLIT)) |-> (rsp_segments_ff == POINT_ONLY))
      else $error("split mode shows digits");

endmodule
